// ===== hdl/sad_pkg.sv =====
// ---------------------------------------------------------------------------
// sad_pkg
// Shared types, constants and arithmetic helpers of the stereo allpass
// diffuser: sample format, register codes, rounding multiply and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

    // sample format, signed Q1.23
    localparam int SW  = 24;
    localparam int SWE = SW + 1;           // difference of two samples
    localparam int SWS = SW + 2;           // sum before saturation

    // Q0.16 factors (amount and stage gain)
    localparam int QW    = 16;
    localparam int AMT_W = 17;
    localparam int PW    = SWE + AMT_W + 1; // product of a SWE sample and a factor

    localparam logic [AMT_W-1:0] AMT_ONE    = 17'd65536;
    localparam logic [AMT_W-1:0] GAIN_BASE  = 17'd22938;
    localparam logic [31:0]      GAIN_SLOPE = 32'd25559;
    localparam logic [31:0]      ROUND_HALF = 32'd32768;

    // configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LDLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RDLY = 2'd2;

    localparam logic [AMT_W-1:0] MIX_RST  = 17'd32768;
    localparam logic [CFG_W-1:0] LDLY_RST = 48'd39244694167701;
    localparam logic [CFG_W-1:0] RDLY_RST = 48'd43231715778738;

    // stage gain at the reset amount
    localparam logic [AMT_W-1:0] GAIN_RST = 17'd35718;

    // packed stage delays
    localparam int DLY_FW      = 12;
    localparam int DLY_NFIELDS = CFG_W / DLY_FW;

    typedef logic signed [SW-1:0] t_sample;

    typedef struct packed {
        logic rd_en;   // transaction accepted, delay read issued
        logic wr_en;   // first stage slot retires, delay write
    } t_stage_ctl;

    localparam logic signed [SWS-1:0] SMAX = SWS'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SWS-1:0] SMIN = -SMAX - SWS'(1);

    function automatic t_sample sat_s(input logic signed [SWS-1:0] v);
        t_sample r;
        if (v > SMAX) begin
            r = SMAX[SW-1:0];
        end else if (v < SMIN) begin
            r = SMIN[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // floor((v * f + 32768) / 65536), rounded half up
    function automatic logic signed [SWE-1:0] mulq16(input logic signed [SWE-1:0] v,
                                                      input logic [AMT_W-1:0] f);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = PW'(v) * PW'($signed({1'b0, f}));
        p = p + PW'($signed({1'b0, ROUND_HALF}));
        q = p >>> QW;
        return q[SWE-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sad_in_if.sv =====
// ---------------------------------------------------------------------------
// sad_in_if
// Input channel of the diffuser: one stereo sample pair per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sad_in_if;
    import sad_pkg::*;

    logic    valid;
    logic    ready;
    t_sample left_in;
    t_sample right_in;

    modport src (output valid, output left_in, output right_in, input ready);
    modport snk (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/sad_out_if.sv =====
// ---------------------------------------------------------------------------
// sad_out_if
// Output channel of the diffuser: one mixed stereo pair per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sad_out_if;
    import sad_pkg::*;

    logic    valid;
    logic    ready;
    t_sample left_out;
    t_sample right_out;

    modport src (output valid, output left_out, output right_out, input ready);
    modport snk (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/stereo_allpass_diffuser_unit.sv =====
// ---------------------------------------------------------------------------
// stereo_allpass_diffuser_unit
// Stereo allpass diffuser: cascaded allpass stages per channel with a
// dry/wet mix, samples signed Q1.23.
// ---------------------------------------------------------------------------
// Usage
//   i_smp takes one stereo pair per transaction (valid/ready), o_res gives
//   one mixed pair per accepted input, in order.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no transaction is in flight: index 0 mix amount, 1 left delays, 2 right
//   delays (four 12-bit stage delays each, stage one lowest).
//   A pair passes through the first slot, the mix input register and the
//   output register to o_res.valid; throughput is one pair per cycle while
//   o_res does not stall. All stages of a channel read their delay memories
//   at acceptance and write them as the pair leaves the first slot, with a
//   bypass for a delay of one that forwards the value being written.
//   Reset restores the register defaults, clears feedback and starts the
//   write position at zero; memory entries not yet written since reset read
//   as zero, so no clearing pass is needed and input is taken at once.
//   When o_res stalls, the pipeline holds at most three pairs; i_smp.ready
//   stays high while any pipeline slot is free or moving.
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_allpass_diffuser_unit #(
    parameter int MAX_DELAY = 4096,
    parameter int STAGES    = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    sad_in_if.snk                                  i_smp,
    sad_out_if.src                                 o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [sad_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sad_pkg::CFG_W-1:0]         i_cfg_data
);
    import sad_pkg::*;

    localparam int WPW = $clog2(MAX_DELAY);
    localparam int WPE = WPW + 1;

    // configuration and derived factors
    logic [AMT_W-1:0] r_mix;
    logic [CFG_W-1:0] r_ldly;
    logic [CFG_W-1:0] r_rdly;
    logic [AMT_W-1:0] r_amt;
    logic [AMT_W-1:0] r_gain;
    logic [AMT_W-1:0] n_amt;
    logic [AMT_W-1:0] n_gain;
    logic [31:0]      gain_p;

    // write position shared by all stages
    logic [WPW-1:0] r_wp;
    logic           r_full;

    // first pipeline slot
    logic           r_v1;
    logic [WPW-1:0] r_wp1;
    t_sample        r_dry_l;
    t_sample        r_dry_r;

    logic       acc;
    logic       adv1;
    logic       mix_ready;
    t_stage_ctl ctl;

    t_sample        y_l  [STAGES];
    t_sample        y_r  [STAGES];
    logic [WPW-1:0] rd_l [STAGES];
    logic [WPW-1:0] rd_r [STAGES];
    logic           ok_l [STAGES];
    logic           ok_r [STAGES];

    function automatic logic [WPW-1:0] f_clamp(input logic [DLY_FW-1:0] f);
        logic [31:0]    fe;
        logic [WPW-1:0] d;
        fe = 32'(f);
        if (fe == 32'd0) begin
            d = WPW'(1);
        end else if (fe > 32'(MAX_DELAY - 1)) begin
            d = WPW'(MAX_DELAY - 1);
        end else begin
            d = WPW'(fe);
        end
        return d;
    endfunction

    always_comb begin
        adv1        = r_v1 && mix_ready;
        i_smp.ready = !r_v1 || adv1;
        acc         = i_smp.valid && i_smp.ready;
        ctl.rd_en   = acc;
        ctl.wr_en   = adv1;
        n_amt       = (r_mix > AMT_ONE) ? AMT_ONE : r_mix;
        gain_p      = GAIN_SLOPE * 32'(n_amt) + ROUND_HALF;
        n_gain      = GAIN_BASE + AMT_W'(gain_p >> QW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix  <= MIX_RST;
            r_ldly <= LDLY_RST;
            r_rdly <= RDLY_RST;
            r_amt  <= MIX_RST;
            r_gain <= GAIN_RST;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_v1   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIX:  r_mix  <= i_cfg_data[AMT_W-1:0];
                    CFG_LDLY: r_ldly <= i_cfg_data;
                    CFG_RDLY: r_rdly <= i_cfg_data;
                    default:  ;
                endcase
            end
            r_amt  <= n_amt;
            r_gain <= n_gain;
            if (acc) begin
                if (r_wp == WPW'(MAX_DELAY - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + WPW'(1);
                end
            end
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_wp1   <= r_wp;
            r_dry_l <= i_smp.left_in;
            r_dry_r <= i_smp.right_in;
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DLY_FW-1:0] fld_l;
        logic [DLY_FW-1:0] fld_r;
        logic [WPW-1:0]    d_l;
        logic [WPW-1:0]    d_r;
        t_sample           x_l;
        t_sample           x_r;

        if (s < DLY_NFIELDS) begin : g_fld
            assign fld_l = r_ldly[s*DLY_FW +: DLY_FW];
            assign fld_r = r_rdly[s*DLY_FW +: DLY_FW];
        end else begin : g_nofld
            assign fld_l = '0;
            assign fld_r = '0;
        end

        if (s == 0) begin : g_first
            assign x_l = r_dry_l;
            assign x_r = r_dry_r;
        end else begin : g_next
            assign x_l = y_l[s-1];
            assign x_r = y_r[s-1];
        end

        // read address (wp - d) mod MAX_DELAY; an entry is written once the
        // ring has wrapped or it lies behind the write position
        always_comb begin
            d_l     = f_clamp(fld_l);
            d_r     = f_clamp(fld_r);
            ok_l[s] = r_full || (r_wp >= d_l);
            ok_r[s] = r_full || (r_wp >= d_r);
            if (r_wp >= d_l) begin
                rd_l[s] = r_wp - d_l;
            end else begin
                rd_l[s] = WPW'({1'b0, r_wp} + WPE'(MAX_DELAY) - {1'b0, d_l});
            end
            if (r_wp >= d_r) begin
                rd_r[s] = r_wp - d_r;
            end else begin
                rd_r[s] = WPW'({1'b0, r_wp} + WPE'(MAX_DELAY) - {1'b0, d_r});
            end
        end

        sad_stage #(
            .DEPTH (MAX_DELAY)
        ) u_stage_l (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_rd_addr (rd_l[s]),
            .i_rd_ok   (ok_l[s]),
            .i_wr_addr (r_wp1),
            .i_gain    (r_gain),
            .i_x       (x_l),
            .o_y       (y_l[s])
        );

        sad_stage #(
            .DEPTH (MAX_DELAY)
        ) u_stage_r (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_rd_addr (rd_r[s]),
            .i_rd_ok   (ok_r[s]),
            .i_wr_addr (r_wp1),
            .i_gain    (r_gain),
            .i_x       (x_r),
            .o_y       (y_r[s])
        );
    end

    sad_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_ready (mix_ready),
        .i_amt   (r_amt),
        .i_wet_l (y_l[STAGES-1]),
        .i_wet_r (y_r[STAGES-1]),
        .i_dry_l (r_dry_l),
        .i_dry_r (r_dry_r),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== hdl/sad_stage.sv =====
// ---------------------------------------------------------------------------
// sad_stage
// One allpass stage of one channel: its delay memory, feedback register,
// write-to-read bypass and the stage arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module sad_stage #(
    parameter int DEPTH = 4096
) (
    input  wire  logic                           i_clk,
    input  wire  logic                           i_rst_n,
    input  wire  sad_pkg::t_stage_ctl            i_ctl,
    input  wire  logic [$clog2(DEPTH)-1:0]       i_rd_addr,
    input  wire  logic                           i_rd_ok,
    input  wire  logic [$clog2(DEPTH)-1:0]       i_wr_addr,
    input  wire  logic [sad_pkg::AMT_W-1:0]      i_gain,
    input  wire  sad_pkg::t_sample               i_x,
    output       sad_pkg::t_sample               o_y
);
    import sad_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_q;
    t_sample r_fwd;
    logic    r_byp;
    logic    r_ok;
    t_sample r_fb;

    t_sample               dly_v;
    logic signed [SWE-1:0] pd;
    logic signed [SWE-1:0] pf;
    t_sample               w;

    // unwritten entries read as zero; a write in the same edge is bypassed
    always_comb begin
        if (r_byp) begin
            dly_v = r_fwd;
        end else if (r_ok) begin
            dly_v = r_q;
        end else begin
            dly_v = '0;
        end
        pd  = mulq16(SWE'(dly_v), i_gain);
        pf  = mulq16(SWE'(r_fb), i_gain);
        o_y = sat_s(SWS'(r_fb) - SWS'(pd));
        w   = sat_s(SWS'(i_x) + SWS'(pf));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q   <= r_mem[i_rd_addr];
            r_fwd <= w;
        end
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
            r_ok  <= 1'b0;
            r_fb  <= '0;
        end else begin
            if (i_ctl.rd_en) begin
                r_byp <= i_ctl.wr_en && (i_rd_addr == i_wr_addr);
                r_ok  <= i_rd_ok;
            end
            if (i_ctl.wr_en) begin
                r_fb <= dly_v;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sad_mix.sv =====
// ---------------------------------------------------------------------------
// sad_mix
// Dry/wet mix of both channels and the output register that drives the
// result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sad_mix (
    input  wire  logic                      i_clk,
    input  wire  logic                      i_rst_n,
    input  wire  logic                      i_valid,
    output       logic                      o_ready,
    input  wire  logic [sad_pkg::AMT_W-1:0] i_amt,
    input  wire  sad_pkg::t_sample          i_wet_l,
    input  wire  sad_pkg::t_sample          i_wet_r,
    input  wire  sad_pkg::t_sample          i_dry_l,
    input  wire  sad_pkg::t_sample          i_dry_r,
    sad_out_if.src                          o_res
);
    import sad_pkg::*;

    logic    r_v2;
    t_sample r_wet_l;
    t_sample r_wet_r;
    t_sample r_dry_l;
    t_sample r_dry_r;
    logic    r_vo;
    t_sample r_out_l;
    t_sample r_out_r;

    logic                  adv_o;
    logic signed [SWE-1:0] m_l;
    logic signed [SWE-1:0] m_r;
    t_sample               n_out_l;
    t_sample               n_out_r;

    always_comb begin
        adv_o   = r_v2 && (!r_vo || o_res.ready);
        o_ready = !r_v2 || adv_o;
        m_l     = mulq16(SWE'(r_wet_l) - SWE'(r_dry_l), i_amt);
        m_r     = mulq16(SWE'(r_wet_r) - SWE'(r_dry_r), i_amt);
        n_out_l = sat_s(SWS'(r_dry_l) + SWS'(m_l));
        n_out_r = sat_s(SWS'(r_dry_r) + SWS'(m_r));
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_wet_l <= i_wet_l;
            r_wet_r <= i_wet_r;
            r_dry_l <= i_dry_l;
            r_dry_r <= i_dry_r;
        end
        if (adv_o) begin
            r_out_l <= n_out_l;
            r_out_r <= n_out_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_v2 <= 1'b1;
            end else if (adv_o) begin
                r_v2 <= 1'b0;
            end
            if (adv_o) begin
                r_vo <= 1'b1;
            end else if (o_res.ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_vo;
    assign o_res.left_out  = r_out_l;
    assign o_res.right_out = r_out_r;

endmodule

`default_nettype wire

// ===== hdl/sad_check.sv =====
// ---------------------------------------------------------------------------
// sad_check
// Port-level checks of the diffuser: reset, output hold, the count of
// transactions in flight, and input readiness while none is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module sad_check (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire sad_pkg::t_sample i_out_left,
    input wire sad_pkg::t_sample i_out_right
);
    import sad_pkg::*;

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready) begin
            n_cnt = n_cnt + 3'd1;
        end
        if (i_out_valid && i_out_ready) begin
            n_cnt = n_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_right))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 3'd0)
        else $error("result without an accepted input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd3)
        else $error("more than three transactions in flight");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> i_in_ready)
        else $error("input stalled while pipeline empty");

endmodule

bind stereo_allpass_diffuser_unit sad_check u_sad_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_left  (o_res.left_out),
    .i_out_right (o_res.right_out)
);

`default_nettype wire
